// ----- design/bfsam_pkg.sv -----
`timescale 1ns / 1ps

package bfsam_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int LABEL_WIDTH  = 32;
    localparam int INDEX_W      = $clog2(MAX_VERTICES);
    localparam int COUNT_W      = $clog2(MAX_VERTICES + 1);

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(MAX_VERTICES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_FETCH,
        S_MASK,
        S_PUSH,
        S_WAIT
    } t_state;

    typedef struct packed {
        logic load;
        logic start;
        logic pop;
        logic fetch;
        logic mask;
        logic push;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic pending_zero;
        logic out_taken;
        logic out_last;
    } t_status;

    // vertices below the clamped count
    function automatic logic [MAX_VERTICES-1:0] count_mask(input logic [COUNT_W-1:0] cnt);
        logic [COUNT_W-1:0]      eff;
        logic [MAX_VERTICES-1:0] m;
        eff = cnt;
        if (cnt == '0) begin
            eff = COUNT_W'(1);
        end else if (cnt > COUNT_W'(MAX_VERTICES)) begin
            eff = COUNT_W'(MAX_VERTICES);
        end
        for (int j = 0; j < MAX_VERTICES; j++) begin
            m[j] = (COUNT_W'(j) < eff);
        end
        return m;
    endfunction

    function automatic logic [INDEX_W-1:0] lowest_index(input logic [MAX_VERTICES-1:0] v);
        logic [INDEX_W-1:0] idx;
        idx = '0;
        for (int j = MAX_VERTICES - 1; j >= 0; j--) begin
            if (v[j]) begin
                idx = INDEX_W'(j);
            end
        end
        return idx;
    endfunction

endpackage

// ----- design/bfsam_ctrl.sv -----
`timescale 1ns / 1ps

module bfsam_ctrl import bfsam_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_last_vertex,
    input  t_status i_status,
    output logic    o_in_stall,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_last_vertex) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_POP;
                    end
                end
            end
            S_POP: begin
                o_cmd.pop = 1'b1;
                n_state   = S_FETCH;
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_MASK;
            end
            S_MASK: begin
                o_cmd.mask = 1'b1;
                n_state    = S_PUSH;
            end
            S_PUSH: begin
                if (i_status.pending_zero) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_WAIT;
                end else begin
                    o_cmd.push = 1'b1;
                end
            end
            S_WAIT: begin
                if (i_status.out_taken) begin
                    n_state = i_status.out_last ? S_IDLE : S_POP;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ----- design/bfsam_dp.sv -----
`timescale 1ns / 1ps

module bfsam_dp import bfsam_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cmd                          i_cmd,
    output t_status                       o_status,
    input  logic                          i_cfg_write,
    input  logic [COUNT_W-1:0]            i_cfg_vertex_count,
    input  logic [INDEX_W-1:0]            i_vertex_index,
    input  logic signed [LABEL_WIDTH-1:0] i_vertex_label,
    input  logic [MAX_VERTICES-1:0]       i_adjacency_row,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic signed [LABEL_WIDTH-1:0] o_visited_label,
    output logic [INDEX_W-1:0]            o_visited_index,
    output logic                          o_last_in_order
);

    logic signed [LABEL_WIDTH-1:0] r_label_store [MAX_VERTICES];
    logic [MAX_VERTICES-1:0]       r_row_store   [MAX_VERTICES];
    logic [INDEX_W-1:0]            r_queue       [MAX_VERTICES];

    logic [COUNT_W-1:0]            r_count;
    logic [MAX_VERTICES-1:0]       r_visited;
    logic [COUNT_W-1:0]            r_head;
    logic [COUNT_W-1:0]            r_tail;
    logic [INDEX_W-1:0]            r_vertex;
    logic signed [LABEL_WIDTH-1:0] r_label;
    logic [MAX_VERTICES-1:0]       r_row;
    logic [MAX_VERTICES-1:0]       r_pending;
    logic                          r_out_valid;
    logic signed [LABEL_WIDTH-1:0] r_out_label;
    logic [INDEX_W-1:0]            r_out_index;
    logic                          r_out_last;

    logic [MAX_VERTICES-1:0]       n_new;
    logic [INDEX_W-1:0]            n_pick;
    logic                          n_room;
    logic                          n_out_taken;

    assign n_new       = r_row & count_mask(r_count) & ~r_visited;
    assign n_pick      = lowest_index(r_pending);
    assign n_room      = (r_tail < COUNT_W'(MAX_VERTICES));
    assign n_out_taken = r_out_valid && !i_out_stall;

    // label and row stores
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_label_store[i_vertex_index] <= i_vertex_label;
            r_row_store[i_vertex_index]   <= i_adjacency_row;
        end
        if (i_cmd.fetch) begin
            r_label <= r_label_store[r_vertex];
            r_row   <= r_row_store[r_vertex];
        end
    end

    // work queue
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_queue[0] <= '0;
        end else if (i_cmd.push && n_room) begin
            r_queue[r_tail[INDEX_W-1:0]] <= n_pick;
        end
        if (i_cmd.pop) begin
            r_vertex <= r_queue[r_head[INDEX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mask) begin
            r_pending <= n_new;
        end else if (i_cmd.push) begin
            r_pending <= r_pending & (r_pending - MAX_VERTICES'(1));
        end
        if (i_cmd.emit) begin
            r_out_label <= r_label;
            r_out_index <= r_vertex;
            r_out_last  <= (r_head == r_tail);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= COUNT_RESET;
            r_visited   <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_write) begin
                r_count <= i_cfg_vertex_count;
            end
            if (i_cmd.start) begin
                r_visited <= MAX_VERTICES'(1);
                r_head    <= '0;
                r_tail    <= COUNT_W'(1);
            end else begin
                if (i_cmd.pop) begin
                    r_head <= r_head + COUNT_W'(1);
                end
                if (i_cmd.mask) begin
                    r_visited <= r_visited | n_new;
                end
                if (i_cmd.push && n_room) begin
                    r_tail <= r_tail + COUNT_W'(1);
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (n_out_taken) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.pending_zero = (r_pending == '0);
    assign o_status.out_taken    = n_out_taken;
    assign o_status.out_last     = r_out_last;

    assign o_out_valid     = r_out_valid;
    assign o_visited_label = r_out_label;
    assign o_visited_index = r_out_index;
    assign o_last_in_order = r_out_last;

endmodule

// ----- design/bfs_adjacency_matrix_order.sv -----
`timescale 1ns / 1ps

// Breadth-first search over an adjacency matrix of up to 16 vertices. Each input transfer
// loads one vertex (label and adjacency row); the transfer marked last starts a search from
// vertex 0 over the first vertex_count vertices, and the block emits the label and index of
// each reachable vertex in visiting order, flagging the final one. For each visited vertex
// the block pops the queue, reads the stores, masks the row, pushes each newly discovered
// neighbor into the queue, then makes the output transfer, which the output may stall. Input
// is stalled for the whole search. vertex_count may only be written while the block is idle.

module bfs_adjacency_matrix_order import bfsam_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [COUNT_W-1:0]            i_cfg_vertex_count,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [INDEX_W-1:0]            i_vertex_index,
    input  logic signed [LABEL_WIDTH-1:0] i_vertex_label,
    input  logic [MAX_VERTICES-1:0]       i_adjacency_row,
    input  logic                          i_last_vertex,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [LABEL_WIDTH-1:0] o_visited_label,
    output logic [INDEX_W-1:0]            o_visited_index,
    output logic                          o_last_in_order
);

    t_cmd    w_cmd;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    bfsam_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_last_vertex (i_last_vertex),
        .i_status      (w_status),
        .o_in_stall    (o_in_stall),
        .o_cmd         (w_cmd)
    );

    bfsam_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .i_cfg_write        (i_cfg_valid),
        .i_cfg_vertex_count (i_cfg_vertex_count),
        .i_vertex_index     (i_vertex_index),
        .i_vertex_label     (i_vertex_label),
        .i_adjacency_row    (i_adjacency_row),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_visited_label    (o_visited_label),
        .o_visited_index    (o_visited_index),
        .o_last_in_order    (o_last_in_order)
    );

endmodule
